// ----- src/bst_pkg.sv -----
// Shared types, character codes and helper functions for the byte stream tokenizer.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package bst_pkg;

   localparam int POSITION_BITS = 16;
   localparam int RSP_DEPTH     = 4;   // power of two
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type     POS_ONE = pos_type'(1);
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam logic [2:0] KW_LENGTH = 3'd6;

   typedef enum logic [3:0] {
      KIND_NUMBER  = 4'd0,
      KIND_STRING  = 4'd1,
      KIND_CHAR    = 4'd2,
      KIND_IDENT   = 4'd3,
      KIND_ASSIGN  = 4'd4,
      KIND_PLUS    = 4'd5,
      KIND_MINUS   = 4'd6,
      KIND_STAR    = 4'd7,
      KIND_SLASH   = 4'd8,
      KIND_EQUALS  = 4'd9,
      KIND_LPAREN  = 4'd10,
      KIND_RPAREN  = 4'd11,
      KIND_UNKNOWN = 4'd12,
      KIND_END     = 4'd13
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_STRING,
      MODE_CHAR_OPEN,
      MODE_CHAR_GOT,
      MODE_IDENT
   } scan_mode_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      logic [7:0]     lone_byte;
      logic           last;
   } token_type;

   // Up to two results per word: a closing token, then the word's own token.
   typedef struct packed {
      logic      a_valid;
      token_type a;
      logic      b_valid;
      token_type b;
   } token_pair_type;

   function automatic token_kind_type symbol_kind(input logic [7:0] b);
      token_kind_type k;
      case (b)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_STAR:   k = KIND_STAR;
         CH_SLASH:  k = KIND_SLASH;
         CH_EQUALS: k = KIND_EQUALS;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         default:   k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // Letters of the keyword "assign", by match position.
   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h61;
         3'd1:    c = 8'h73;
         3'd2:    c = 8'h73;
         3'd3:    c = 8'h69;
         3'd4:    c = 8'h67;
         3'd5:    c = 8'h6E;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic token_type form_token(input token_kind_type kind, input pos_type start,
                                            input logic [15:0] length, input logic [7:0] b);
      token_type t;
      t.kind      = kind;
      t.start     = 16'(start);
      t.length    = length;
      t.lone_byte = b;
      t.last      = 1'b0;
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- src/bst_if.sv -----
// Channel interfaces for the tokenizer: source text words in, token words out.
// Depends on nothing; payload widths follow the channel field list.
`default_nettype none

interface bst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_input;

   modport source(output valid, output text_byte, output end_of_input, input ready);
   modport sink(input valid, input text_byte, input end_of_input, output ready);
endinterface

interface bst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [7:0]  lone_byte;
   logic        last_result;

   modport source(output valid, output token_kind, output token_start, output token_length,
                  output lone_byte, output last_result, input ready);
   modport sink(input valid, input token_kind, input token_start, input token_length,
                input lone_byte, input last_result, output ready);
endinterface

`default_nettype wire

// ----- src/byte_stream_tokenizer_top.sv -----
// Byte stream tokenizer: each token is registered in the result queue, then offered on rsp_chan.
// Takes one text word per cycle while the four-entry result queue has two free slots; a word
// that closes a token and emits its own drains at one token per cycle while rsp_chan is ready.
// Synchronous reset empties the queue, sets the scanner idle and the position to zero.
// An end mark or NUL byte also sets the position to zero.
// Depends on bst_pkg, bst_if, bst_scan and bst_rsp_fifo.
`default_nettype none

module byte_stream_tokenizer_top (
   input logic       clock,
   input logic       reset,
   bst_req_if.sink   req_chan,
   bst_rsp_if.source rsp_chan
);

   bst_pkg::token_pair_type push;
   bst_pkg::token_type      head_tok;
   logic                    room, fire;

   assign req_chan.ready = room;
   assign fire           = req_chan.valid && room;

   bst_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .text_byte    (req_chan.text_byte),
      .end_of_input (req_chan.end_of_input),
      .push         (push)
   );

   bst_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_token (head_tok)
   );

   assign rsp_chan.token_kind   = head_tok.kind;
   assign rsp_chan.token_start  = head_tok.start;
   assign rsp_chan.token_length = head_tok.length;
   assign rsp_chan.lone_byte    = head_tok.lone_byte;
   assign rsp_chan.last_result  = head_tok.last;

endmodule

`default_nettype wire

// ----- src/bst_scan.sv -----
// Scanner state and per-word token logic: one word in, up to two tokens out.
// Depends on bst_pkg.
`default_nettype none

module bst_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              text_byte,
   input  logic                    end_of_input,
   output bst_pkg::token_pair_type push
);

   bst_pkg::scan_mode_type mode_ff, mode_in;
   bst_pkg::pos_type       pos_ff, pos_in;
   bst_pkg::pos_type       start_ff, start_in;
   logic [15:0]            len_ff, len_in;
   logic [2:0]             kwp_ff, kwp_in;
   logic                   kwm_ff, kwm_in;
   logic [7:0]             held_ff, held_in;

   logic                   end_w, is_digit, is_alpha, is_space, is_dq, is_sq, is_dot;
   logic                   idle_emit, rescan, kw_hit, kw_done;
   logic [15:0]            len_grow;
   bst_pkg::token_type     idle_tok, ident_tok, tok_a, tok_b;
   logic                   a_valid, b_valid;

   assign end_w    = end_of_input || (text_byte == bst_pkg::CH_NUL);
   assign is_digit = text_byte inside {[bst_pkg::CH_ZERO:bst_pkg::CH_NINE]};
   assign is_alpha = text_byte inside {[bst_pkg::CH_UPPER_A:bst_pkg::CH_UPPER_Z],
                                       [bst_pkg::CH_LOWER_A:bst_pkg::CH_LOWER_Z]};
   assign is_space = text_byte inside {bst_pkg::CH_SPACE, [bst_pkg::CH_TAB:bst_pkg::CH_CR]};
   assign is_dq    = (text_byte == bst_pkg::CH_DQUOTE);
   assign is_sq    = (text_byte == bst_pkg::CH_SQUOTE);
   assign is_dot   = (text_byte == bst_pkg::CH_DOT);
   assign idle_emit = !(is_space || is_digit || is_dq || is_sq || is_alpha);

   assign len_grow = (len_ff != bst_pkg::LEN_MAX) ? len_ff + 16'd1 : len_ff;
   assign kw_hit   = kwm_ff && (kwp_ff < bst_pkg::KW_LENGTH)
                     && (text_byte == bst_pkg::keyword_char(kwp_ff));
   assign kw_done  = kwm_ff && (kwp_ff == bst_pkg::KW_LENGTH);

   assign idle_tok  = bst_pkg::form_token(bst_pkg::symbol_kind(text_byte), pos_ff, 16'd1,
                                          text_byte);
   assign ident_tok = bst_pkg::form_token(kw_done ? bst_pkg::KIND_ASSIGN : bst_pkg::KIND_IDENT,
                                          start_ff, len_ff, bst_pkg::CH_NUL);

   // Next state
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      kwp_in   = kwp_ff;
      kwm_in   = kwm_ff;
      held_in  = held_ff;
      rescan   = 1'b0;
      if (fire) begin
         if (end_w) begin
            mode_in  = bst_pkg::MODE_IDLE;
            pos_in   = '0;
            start_in = '0;
            len_in   = '0;
            kwp_in   = '0;
            kwm_in   = 1'b1;
            held_in  = '0;
         end else begin
            pos_in = pos_ff + bst_pkg::POS_ONE;
            case (mode_ff)
               bst_pkg::MODE_NUMBER: begin
                  if (is_digit || is_dot) len_in = len_grow;
                  else rescan = 1'b1;
               end
               bst_pkg::MODE_IDENT: begin
                  if (is_digit || is_alpha) begin
                     len_in = len_grow;
                     if (kw_hit) kwp_in = kwp_ff + 3'd1;
                     else kwm_in = 1'b0;
                  end else begin
                     rescan = 1'b1;
                  end
               end
               bst_pkg::MODE_STRING: begin
                  if (is_dq) mode_in = bst_pkg::MODE_IDLE;
                  else len_in = len_grow;
               end
               bst_pkg::MODE_CHAR_OPEN: begin
                  held_in  = text_byte;
                  start_in = pos_ff;
                  len_in   = 16'd1;
                  mode_in  = bst_pkg::MODE_CHAR_GOT;
               end
               bst_pkg::MODE_CHAR_GOT: begin
                  mode_in = bst_pkg::MODE_IDLE;
                  rescan  = !is_sq;
               end
               default: rescan = 1'b1;
            endcase
         end
      end
      // Scan the word from idle: open a token or stay idle
      if (rescan) begin
         mode_in = bst_pkg::MODE_IDLE;
         if (is_digit) begin
            mode_in  = bst_pkg::MODE_NUMBER;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (is_dq) begin
            mode_in  = bst_pkg::MODE_STRING;
            start_in = pos_ff + bst_pkg::POS_ONE;
            len_in   = 16'd0;
         end else if (is_sq) begin
            mode_in = bst_pkg::MODE_CHAR_OPEN;
         end else if (is_alpha) begin
            mode_in  = bst_pkg::MODE_IDENT;
            start_in = pos_ff;
            len_in   = 16'd1;
            kwm_in   = (text_byte == bst_pkg::keyword_char(3'd0));
            kwp_in   = kwm_in ? 3'd1 : 3'd0;
         end
      end
   end

   // Token outputs
   always_comb begin
      a_valid = 1'b0;
      b_valid = 1'b0;
      tok_a   = ident_tok;
      tok_b   = idle_tok;
      if (end_w) begin
         b_valid = 1'b1;
         tok_b   = bst_pkg::form_token(bst_pkg::KIND_END, pos_ff, 16'd0, bst_pkg::CH_NUL);
         case (mode_ff)
            bst_pkg::MODE_NUMBER: begin
               a_valid = 1'b1;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_NUMBER, start_ff, len_ff,
                                             bst_pkg::CH_NUL);
            end
            bst_pkg::MODE_STRING: begin
               a_valid = 1'b1;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_STRING, start_ff, len_ff,
                                             bst_pkg::CH_NUL);
            end
            bst_pkg::MODE_CHAR_OPEN: begin
               // char cut off by the end: empty token at the end position
               a_valid = 1'b1;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_CHAR, pos_ff, 16'd0,
                                             bst_pkg::CH_NUL);
            end
            bst_pkg::MODE_CHAR_GOT: begin
               a_valid = 1'b1;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_CHAR, start_ff, 16'd1, held_ff);
            end
            bst_pkg::MODE_IDENT: a_valid = 1'b1;
            default: a_valid = 1'b0;
         endcase
      end else begin
         case (mode_ff)
            bst_pkg::MODE_NUMBER: begin
               a_valid = !(is_digit || is_dot);
               b_valid = a_valid && idle_emit;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_NUMBER, start_ff, len_ff,
                                             bst_pkg::CH_NUL);
            end
            bst_pkg::MODE_IDENT: begin
               a_valid = !(is_digit || is_alpha);
               b_valid = a_valid && idle_emit;
            end
            bst_pkg::MODE_STRING: begin
               a_valid = is_dq;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_STRING, start_ff, len_ff,
                                             bst_pkg::CH_NUL);
            end
            bst_pkg::MODE_CHAR_OPEN: a_valid = 1'b0;
            bst_pkg::MODE_CHAR_GOT: begin
               a_valid = 1'b1;
               b_valid = !is_sq && idle_emit;
               tok_a   = bst_pkg::form_token(bst_pkg::KIND_CHAR, start_ff, 16'd1, held_ff);
            end
            default: b_valid = idle_emit;
         endcase
      end
      tok_a.last = !b_valid;
      tok_b.last = 1'b1;
   end

   assign push.a_valid = fire && a_valid;
   assign push.a       = tok_a;
   assign push.b_valid = fire && b_valid;
   assign push.b       = tok_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bst_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         kwp_ff   <= '0;
         kwm_ff   <= 1'b1;
         held_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kwp_ff   <= kwp_in;
         kwm_ff   <= kwm_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/bst_rsp_fifo.sv -----
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// Depends on bst_pkg.
`default_nettype none

module bst_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  bst_pkg::token_pair_type push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bst_pkg::token_type      out_token
);

   bst_pkg::token_type                ent_ff [bst_pkg::RSP_DEPTH];
   logic [bst_pkg::RSP_PTR_BITS-1:0]  head_ff, head_in, tail_ff, tail_in, tail_next;
   logic [bst_pkg::RSP_CNT_BITS-1:0]  count_ff, count_in;
   logic                              wr0_en, wr1_en, pop;
   bst_pkg::token_type                wr0_tok;

   // Pack the pair: the second token slides down when the first is absent
   assign wr0_en  = push.a_valid || push.b_valid;
   assign wr1_en  = push.a_valid && push.b_valid;
   assign wr0_tok = push.a_valid ? push.a : push.b;

   assign tail_next = tail_ff + 1'b1;
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_token = ent_ff[head_ff];
   assign room      = (count_ff <= bst_pkg::RSP_CNT_BITS'(bst_pkg::RSP_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + bst_pkg::RSP_PTR_BITS'(wr0_en) + bst_pkg::RSP_PTR_BITS'(wr1_en);
      count_in = count_ff + bst_pkg::RSP_CNT_BITS'(wr0_en) + bst_pkg::RSP_CNT_BITS'(wr1_en)
                 - bst_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0_en) ent_ff[tail_ff] <= wr0_tok;
      if (wr1_en) ent_ff[tail_next] <= push.b;
   end

endmodule

`default_nettype wire

// ----- src/bst_checker.sv -----
// Port-level checks for the tokenizer, attached to the top level by bind.
// Depends on bst_pkg and byte_stream_tokenizer_top.
`default_nettype none

module bst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_text_byte,
   input logic        req_end_of_input,
   input logic        rsp_valid,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_lone_byte,
   input logic        rsp_last_result
);

   // Reset leaves no token waiting
   a_reset_empty: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("token offered right after reset");

   // An accepted end always yields a token next cycle
   a_end_yields: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_end_of_input || req_text_byte == bst_pkg::CH_NUL))
      |=> rsp_valid)
      else $error("end word produced no token");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == bst_pkg::KIND_END)
      |-> (rsp_last_result && rsp_token_length == 16'd0 && rsp_lone_byte == 8'h00))
      else $error("malformed end token");

   a_symbol_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind >= bst_pkg::KIND_PLUS
                 && rsp_token_kind <= bst_pkg::KIND_UNKNOWN)
      |-> (rsp_token_length == 16'd1))
      else $error("one-byte token with wrong length");

   a_text_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_token_kind == bst_pkg::KIND_NUMBER
                  || rsp_token_kind == bst_pkg::KIND_STRING
                  || rsp_token_kind == bst_pkg::KIND_IDENT
                  || rsp_token_kind == bst_pkg::KIND_ASSIGN))
      |-> (rsp_lone_byte == 8'h00))
      else $error("multi-byte token carries a lone byte");

endmodule

bind byte_stream_tokenizer_top bst_checker u_bst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_text_byte    (req_chan.text_byte),
   .req_end_of_input (req_chan.end_of_input),
   .rsp_valid        (rsp_chan.valid),
   .rsp_token_kind   (rsp_chan.token_kind),
   .rsp_token_length (rsp_chan.token_length),
   .rsp_lone_byte    (rsp_chan.lone_byte),
   .rsp_last_result  (rsp_chan.last_result)
);

`default_nettype wire
